### design/ptpd_pkg.sv
// Shared types and width constants for the point-to-plane distance pipeline.
package ptpd_pkg;

  localparam int COORD_BITS = 24;
  localparam int DIST_BITS  = 25;

  // Edge and offset vectors, cross-product terms and the normal.
  localparam int EW  = COORD_BITS + 1;
  localparam int PW  = 2 * EW;
  localparam int NW  = 2 * EW + 1;
  // The normal is split into a low unsigned and a high signed half for multiplication.
  localparam int NLO = NW / 2;
  localparam int NHI = NW - NLO;
  // Squared normal length, its triple, and the signed normal dot offset.
  localparam int N2W = 2 * NW + 2;
  localparam int N3W = N2W + 2;
  localparam int DW  = NW + EW + 2;
  // The dot product is split into three chunks for squaring.
  localparam int DLO = (DW + 2) / 3;
  localparam int DHI = DW - 2 * DLO;
  // Remainder and trial term width of the digit search.
  localparam int RW  = 2 * DW + 2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] p0_x;
    logic signed [COORD_BITS-1:0] p0_y;
    logic signed [COORD_BITS-1:0] p0_z;
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
    logic signed [COORD_BITS-1:0] p1_z;
    logic signed [COORD_BITS-1:0] p2_x;
    logic signed [COORD_BITS-1:0] p2_y;
    logic signed [COORD_BITS-1:0] p2_z;
    logic signed [COORD_BITS-1:0] q_x;
    logic signed [COORD_BITS-1:0] q_y;
    logic signed [COORD_BITS-1:0] q_z;
  } pt_word_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic                 degenerate;
  } dist_word_t;

endpackage

### design/point_to_plane_distance_top.sv
// Pipelined perpendicular distance of a query point from a three-point plane.
// Throughput: one word per cycle; the whole pipeline advances together and holds
// while a result word waits on the output. The distance bits come from 25
// digit-search stages, one bit per stage.
// Reset clears only the valid bits of the pipeline; no result is pending after it.
module point_to_plane_distance_top
  import ptpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       pt_valid,
  output logic       pt_ready,
  input  pt_word_t   pt,
  output logic       dist_valid,
  input  logic       dist_ready,
  output dist_word_t dist_word
);

  logic en;

  // Stage 1: edge and offset vectors.
  logic                 v1;
  logic signed [EW-1:0] s1_a [3];
  logic signed [EW-1:0] s1_b [3];
  logic signed [EW-1:0] s1_o [3];

  // Stage 2: cross-product terms.
  logic                 v2;
  logic signed [PW-1:0] s2_pp [3];
  logic signed [PW-1:0] s2_pm [3];
  logic signed [EW-1:0] s2_o  [3];

  // Stage 3: normal.
  logic                 v3;
  logic                 s3_deg;
  logic signed [NW-1:0] s3_n [3];
  logic signed [EW-1:0] s3_o [3];

  // Stage 4: partial products.
  logic                       v4;
  logic                       s4_deg;
  logic signed [NHI+EW-1:0]   s4_dh [3];
  logic signed [NLO+EW:0]     s4_dl [3];
  logic signed [2*NHI-1:0]    s4_hh [3];
  logic signed [NHI+NLO:0]    s4_hl [3];
  logic        [2*NLO-1:0]    s4_ll [3];

  // Stage 5: per-axis products.
  logic                  v5;
  logic                  s5_deg;
  logic signed [DW-1:0]  s5_d  [3];
  logic signed [N2W-1:0] s5_n2 [3];

  // Stage 6: dot product and squared normal length.
  logic                 v6;
  logic                 s6_deg;
  logic signed [DW-1:0] s6_d;
  logic [N2W-1:0]       s6_n2;

  // Stage 7: partial products of the squared dot product.
  logic                         v7;
  logic                         s7_deg;
  logic [N2W-1:0]               s7_n2;
  logic [2*DLO-1:0]             s7_00;
  logic [2*DLO-1:0]             s7_11;
  logic [2*DLO-1:0]             s7_01;
  logic signed [2*DHI-1:0]      s7_22;
  logic signed [DLO+DHI:0]      s7_02;
  logic signed [DLO+DHI:0]      s7_12;

  // Digit search, stage j works on distance bit DIST_BITS-1-j.
  logic                 sr_v   [DIST_BITS+1];
  logic                 sr_deg [DIST_BITS+1];
  logic [DIST_BITS-1:0] sr_d   [DIST_BITS+1];
  logic [RW-1:0]        sr_r   [DIST_BITS];
  logic [RW-1:0]        sr_t   [DIST_BITS];
  logic [N2W-1:0]       sr_n2  [DIST_BITS];
  logic [N3W-1:0]       sr_n3  [DIST_BITS];

  assign en         = !sr_v[DIST_BITS] || dist_ready;
  assign pt_ready   = en;
  assign dist_valid = sr_v[DIST_BITS];
  assign dist_word.distance   = sr_deg[DIST_BITS] ? '0 : sr_d[DIST_BITS];
  assign dist_word.degenerate = sr_deg[DIST_BITS];

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      sr_v[0] <= 1'b0;
    end else if (en) begin
      v1 <= pt_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      sr_v[0] <= v7;
    end
  end

  // Front stages payload.
  logic signed [NHI-1:0]   nhi [3];
  logic        [NLO-1:0]   nlo [3];
  logic        [DLO-1:0]   dc0;
  logic        [DLO-1:0]   dc1;
  logic signed [DHI-1:0]   dc2;
  logic signed [RW-1:0]    d2_sum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nhi[i] = s3_n[i][NW-1:NLO];
      nlo[i] = s3_n[i][NLO-1:0];
    end
    dc0 = s6_d[DLO-1:0];
    dc1 = s6_d[2*DLO-1:DLO];
    dc2 = s6_d[DW-1:2*DLO];
    d2_sum = RW'(s7_00)
           + (RW'(s7_01) << (DLO + 1))
           + (RW'(s7_11) << (2 * DLO))
           + (RW'(s7_02) <<< (2 * DLO + 1))
           + (RW'(s7_12) <<< (3 * DLO + 1))
           + (RW'(s7_22) <<< (4 * DLO));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a[0] <= EW'(pt.p1_x) - EW'(pt.p0_x);
      s1_a[1] <= EW'(pt.p1_y) - EW'(pt.p0_y);
      s1_a[2] <= EW'(pt.p1_z) - EW'(pt.p0_z);
      s1_b[0] <= EW'(pt.p2_x) - EW'(pt.p0_x);
      s1_b[1] <= EW'(pt.p2_y) - EW'(pt.p0_y);
      s1_b[2] <= EW'(pt.p2_z) - EW'(pt.p0_z);
      s1_o[0] <= EW'(pt.q_x) - EW'(pt.p0_x);
      s1_o[1] <= EW'(pt.q_y) - EW'(pt.p0_y);
      s1_o[2] <= EW'(pt.q_z) - EW'(pt.p0_z);

      s2_pp[0] <= s1_a[1] * s1_b[2];
      s2_pm[0] <= s1_a[2] * s1_b[1];
      s2_pp[1] <= s1_a[2] * s1_b[0];
      s2_pm[1] <= s1_a[0] * s1_b[2];
      s2_pp[2] <= s1_a[0] * s1_b[1];
      s2_pm[2] <= s1_a[1] * s1_b[0];
      s2_o     <= s1_o;

      for (int i = 0; i < 3; i++) begin
        s3_n[i] <= NW'(s2_pp[i]) - NW'(s2_pm[i]);
      end
      s3_deg <= (s2_pp[0] == s2_pm[0]) && (s2_pp[1] == s2_pm[1]) &&
                (s2_pp[2] == s2_pm[2]);
      s3_o   <= s2_o;

      for (int i = 0; i < 3; i++) begin
        s4_dh[i] <= nhi[i] * s3_o[i];
        s4_dl[i] <= $signed({1'b0, nlo[i]}) * s3_o[i];
        s4_hh[i] <= nhi[i] * nhi[i];
        s4_hl[i] <= nhi[i] * $signed({1'b0, nlo[i]});
        s4_ll[i] <= nlo[i] * nlo[i];
      end
      s4_deg <= s3_deg;

      for (int i = 0; i < 3; i++) begin
        s5_d[i]  <= (DW'(s4_dh[i]) <<< NLO) + DW'(s4_dl[i]);
        s5_n2[i] <= (N2W'(s4_hh[i]) <<< (2 * NLO)) + (N2W'(s4_hl[i]) <<< (NLO + 1))
                  + N2W'(s4_ll[i]);
      end
      s5_deg <= s4_deg;

      s6_d   <= s5_d[0] + s5_d[1] + s5_d[2];
      s6_n2  <= s5_n2[0] + s5_n2[1] + s5_n2[2];
      s6_deg <= s5_deg;

      s7_00  <= dc0 * dc0;
      s7_11  <= dc1 * dc1;
      s7_01  <= dc0 * dc1;
      s7_22  <= dc2 * dc2;
      s7_02  <= $signed({1'b0, dc0}) * dc2;
      s7_12  <= $signed({1'b0, dc1}) * dc2;
      s7_n2  <= s6_n2;
      s7_deg <= s6_deg;

      // The first trial term is the top bit squared times the normal length.
      sr_r[0]   <= d2_sum;
      sr_t[0]   <= RW'(s7_n2) << (2 * (DIST_BITS - 1));
      sr_n2[0]  <= s7_n2;
      sr_n3[0]  <= N3W'(s7_n2) + (N3W'(s7_n2) << 1);
      sr_d[0]   <= '0;
      sr_deg[0] <= s7_deg;
    end
  end

  // Restoring digit search: the remainder holds the squared dot product minus
  // the accepted distance squared times the normal length; the trial term for the
  // next bit is updated by a shift and an add (taken) or a subtract (not taken).
  for (genvar j = 0; j < DIST_BITS; j++) begin : g_search
    localparam int K = DIST_BITS - 1 - j;
    logic [RW:0] diff;
    logic        take;

    assign diff = {1'b0, sr_r[j]} - {1'b0, sr_t[j]};
    assign take = !diff[RW];

    always_ff @(posedge clk) begin
      if (rst) begin
        sr_v[j+1] <= 1'b0;
      end else if (en) begin
        sr_v[j+1] <= sr_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sr_d[j+1]   <= {sr_d[j][DIST_BITS-2:0], take};
        sr_deg[j+1] <= sr_deg[j];
      end
    end

    if (K > 0) begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          sr_r[j+1]  <= take ? diff[RW-1:0] : sr_r[j];
          sr_t[j+1]  <= take ? (sr_t[j] >> 1) + (RW'(sr_n3[j]) << (2 * (K - 1)))
                             : (sr_t[j] >> 1) - (RW'(sr_n2[j]) << (2 * (K - 1)));
          sr_n2[j+1] <= sr_n2[j];
          sr_n3[j+1] <= sr_n3[j];
        end
      end
    end
  end

  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    pt_valid && pt_ready |=> v1)
    else $error("accepted word did not enter the pipeline");

  a_deg_matches_normal : assert property (@(posedge clk) disable iff (rst)
    v3 |-> (s3_deg == ((s3_n[0] == '0) && (s3_n[1] == '0) && (s3_n[2] == '0))))
    else $error("degenerate flag disagrees with the normal");

  a_result_from_search : assert property (@(posedge clk) disable iff (rst)
    $rose(dist_valid) |-> $past(sr_v[DIST_BITS-1]))
    else $error("result word appeared without a word in the last search stage");

endmodule
